### src/aar_pkg.sv
// aar_pkg: shared types, constants and helper functions of the area average downscaler
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package aar_pkg;

   // default frame store size
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;
   localparam int DEST_LIMIT     = 2048;

   // field and internal widths
   localparam int POS_W   = 11;   // column / row fields
   localparam int REG_W   = 12;   // configuration registers
   localparam int IDX_W   = 13;   // source pixel index
   localparam int CRD_W   = 25;   // scaled footprint coordinates
   localparam int SPAN_W  = 12;   // overlap span on one axis
   localparam int WGT_W   = 24;   // pixel weight
   localparam int WA_W    = 32;   // weight times alpha
   localparam int ACC_A_W = 34;   // alpha accumulator
   localparam int ACC_C_W = 42;   // color accumulators
   localparam int WSUM_W  = 26;   // weight accumulator
   localparam int DIV_W   = 44;   // shared divider width
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int CSR_A_W = 2;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 56;

   // register indexes
   localparam logic [CSR_A_W-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_A_W-1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_A_W-1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [CSR_A_W-1:0] REG_DST_HEIGHT = 2'd3;

   // item kinds
   localparam logic MODE_WRITE   = 1'b0;
   localparam logic MODE_REQUEST = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_X,
      ST_EDGE_Y,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ROW,
      ST_ROW_CHK,
      ST_ROW_NEXT,
      ST_COL,
      ST_COL_CHK,
      ST_AMUL,
      ST_ACC,
      ST_COL_NEXT,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      DIV_IX0,
      DIV_IX1,
      DIV_IY0,
      DIV_IY1,
      DIV_ALPHA,
      DIV_RED,
      DIV_GREEN,
      DIV_BLUE
   } div_sel_type;

   typedef struct packed {
      logic        accept_write;
      logic        accept_req;
      logic        edge_x;
      logic        edge_y;
      logic        div_start;
      div_sel_type div_sel;
      logic        row_calc;
      logic        sy_inc;
      logic        col_calc;
      logic        sx_inc;
      logic        wmul;
      logic        amul;
      logic        acc;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic row_ok;
      logic col_ok;
      logic sx_last;
      logic sy_last;
      logic wsum_nz;
      logic acca_nz;
      logic div_done;
      logic out_free;
   } status_type;

   // zero counts as one, too large saturates to top
   function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v, input int top);
      logic [REG_W-1:0] r;
      begin
         r = v;
         if (v == '0) begin
            r = REG_W'(1);
         end else if (32'(v) > top) begin
            r = REG_W'(top);
         end
         return r;
      end
   endfunction

   // saturate a rounded quotient to one channel
   function automatic logic [7:0] sat8(input logic [DIV_W-1:0] q);
      logic [7:0] r;
      begin
         r = (q > DIV_W'(255)) ? 8'hFF : q[7:0];
         return r;
      end
   endfunction

endpackage

### src/aar_div.sv
// aar_div: restoring divider, one quotient bit per cycle
// uses aar_pkg for widths
`timescale 1ns / 1ps

module aar_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [aar_pkg::DIV_W-1:0] num,
   input  logic [aar_pkg::DIV_W-1:0] den,
   output logic                     done,
   output logic [aar_pkg::DIV_W-1:0] quo
);

   localparam int DW = aar_pkg::DIV_W;
   localparam int CW = aar_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   rem_sh;
   logic [DW+1:0] diff;

   // one shift and subtract step
   always_comb begin
      rem_sh  = {rem_ff[DW-1:0], quo_ff[DW-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (!diff[DW+1]) begin
            rem_in = diff[DW:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### src/aar_dp.sv
// aar_dp: datapath with frame store, configuration registers, footprint walk and accumulators
// uses aar_pkg and aar_div; driven by aar_ctrl commands
`timescale 1ns / 1ps

module aar_dp #(
   parameter int MAX_WIDTH  = aar_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = aar_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [aar_pkg::CSR_A_W-1:0]       csr_addr,
   input  logic [aar_pkg::REG_W-1:0]         csr_wdata,
   input  logic [aar_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [aar_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  aar_pkg::cmd_type                  cmd,
   output aar_pkg::status_type               status
);

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int MEM_DEPTH = 2 ** (XW + YW);
   localparam int PW = aar_pkg::POS_W;
   localparam int RW = aar_pkg::REG_W;
   localparam int IW = aar_pkg::IDX_W;
   localparam int CW = aar_pkg::CRD_W;
   localparam int SW = aar_pkg::SPAN_W;
   localparam int DW = aar_pkg::DIV_W;

   // request fields
   logic [PW-1:0] src_col, src_row, dst_col, dst_row;
   logic [31:0]   in_pixel;
   assign src_col  = req_tdata[10:0];
   assign src_row  = req_tdata[21:11];
   assign in_pixel = req_tdata[53:22];
   assign dst_col  = req_tdata[64:54];
   assign dst_row  = req_tdata[75:65];

   // configuration registers
   logic [RW-1:0] sw_ff, sh_ff, dw_ff, dh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= RW'(1);
         sh_ff <= RW'(1);
         dw_ff <= RW'(1);
         dh_ff <= RW'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            aar_pkg::REG_SRC_WIDTH:  sw_ff <= aar_pkg::clamp_reg(csr_wdata, MAX_WIDTH);
            aar_pkg::REG_SRC_HEIGHT: sh_ff <= aar_pkg::clamp_reg(csr_wdata, MAX_HEIGHT);
            aar_pkg::REG_DST_WIDTH:  dw_ff <= aar_pkg::clamp_reg(csr_wdata, aar_pkg::DEST_LIMIT);
            aar_pkg::REG_DST_HEIGHT: dh_ff <= aar_pkg::clamp_reg(csr_wdata, aar_pkg::DEST_LIMIT);
            default: ;
         endcase
      end
   end

   // walk state
   logic [PW-1:0] dx_ff, dy_ff;
   logic [CW-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [IW-1:0] ix0_ff, ix1_ff, iy1_ff, sx_ff, sy_ff;
   logic [SW-1:0] wy_ff, colw_ff;
   logic          row_ok_ff, col_ok_ff;
   logic [31:0]   pix_ff;
   logic [aar_pkg::WGT_W-1:0]   w_ff;
   logic [aar_pkg::WA_W-1:0]    wa_ff;
   logic [aar_pkg::ACC_C_W-1:0] acc_r_ff, acc_g_ff, acc_b_ff;
   logic [aar_pkg::ACC_A_W-1:0] acc_a_ff;
   logic [aar_pkg::WSUM_W-1:0]  wsum_ff;
   logic [7:0]    res_r_ff, res_g_ff, res_b_ff, res_a_ff;

   // frame store
   logic [31:0] frame_mem_ff [MEM_DEPTH];
   logic        wr_ok;
   assign wr_ok = (32'(src_col) < MAX_WIDTH) && (32'(src_row) < MAX_HEIGHT);

   always_ff @(posedge clock) begin
      if (cmd.accept_write && wr_ok) begin
         frame_mem_ff[{YW'(src_row), XW'(src_col)}] <= in_pixel;
      end
      if (cmd.col_calc) begin
         pix_ff <= frame_mem_ff[{sy_ff[YW-1:0], sx_ff[XW-1:0]}];
      end
   end

   // row and column overlap
   logic [CW-1:0] row_lo_raw, row_hi_raw, row_lo, row_hi;
   logic [CW-1:0] col_lo_raw, col_hi_raw, col_lo, col_hi;
   always_comb begin
      row_lo_raw = CW'(sy_ff) * CW'(dh_ff);
      row_hi_raw = row_lo_raw + CW'(dh_ff);
      row_lo     = (row_lo_raw < y0_ff) ? y0_ff : row_lo_raw;
      row_hi     = (row_hi_raw > y1_ff) ? y1_ff : row_hi_raw;
      col_lo_raw = CW'(sx_ff) * CW'(dw_ff);
      col_hi_raw = col_lo_raw + CW'(dw_ff);
      col_lo     = (col_lo_raw < x0_ff) ? x0_ff : col_lo_raw;
      col_hi     = (col_hi_raw > x1_ff) ? x1_ff : col_hi_raw;
   end

   // footprint edge product
   logic [CW-1:0] edge_prod_x, edge_prod_y;
   assign edge_prod_x = CW'(dx_ff) * CW'(sw_ff);
   assign edge_prod_y = CW'(dy_ff) * CW'(sh_ff);

   // divider operands
   logic [DW-1:0] div_num, div_den, div_quo;
   logic [CW-1:0] div_qc;
   logic          div_done;
   always_comb begin
      case (cmd.div_sel)
         aar_pkg::DIV_IX0: begin
            div_num = DW'(x0_ff);
            div_den = DW'(dw_ff);
         end
         aar_pkg::DIV_IX1: begin
            div_num = DW'(x1_ff) + DW'(dw_ff) - DW'(1);
            div_den = DW'(dw_ff);
         end
         aar_pkg::DIV_IY0: begin
            div_num = DW'(y0_ff);
            div_den = DW'(dh_ff);
         end
         aar_pkg::DIV_IY1: begin
            div_num = DW'(y1_ff) + DW'(dh_ff) - DW'(1);
            div_den = DW'(dh_ff);
         end
         aar_pkg::DIV_ALPHA: begin
            div_num = DW'({acc_a_ff, 1'b0}) + DW'(wsum_ff);
            div_den = DW'({wsum_ff, 1'b0});
         end
         aar_pkg::DIV_RED: begin
            div_num = DW'({acc_r_ff, 1'b0}) + DW'(acc_a_ff);
            div_den = DW'({acc_a_ff, 1'b0});
         end
         aar_pkg::DIV_GREEN: begin
            div_num = DW'({acc_g_ff, 1'b0}) + DW'(acc_a_ff);
            div_den = DW'({acc_a_ff, 1'b0});
         end
         default: begin
            div_num = DW'({acc_b_ff, 1'b0}) + DW'(acc_a_ff);
            div_den = DW'({acc_a_ff, 1'b0});
         end
      endcase
   end

   aar_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign div_qc = div_quo[CW-1:0];

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.accept_req) begin
         dx_ff    <= dst_col;
         dy_ff    <= dst_row;
         acc_r_ff <= '0;
         acc_g_ff <= '0;
         acc_b_ff <= '0;
         acc_a_ff <= '0;
         wsum_ff  <= '0;
         res_r_ff <= '0;
         res_g_ff <= '0;
         res_b_ff <= '0;
         res_a_ff <= '0;
      end
      if (cmd.edge_x) begin
         x0_ff <= edge_prod_x;
         x1_ff <= edge_prod_x + CW'(sw_ff);
      end
      if (cmd.edge_y) begin
         y0_ff <= edge_prod_y;
         y1_ff <= edge_prod_y + CW'(sh_ff);
      end
      // quotient capture
      if (div_done) begin
         case (cmd.div_sel)
            aar_pkg::DIV_IX0: ix0_ff <= IW'(div_qc);
            aar_pkg::DIV_IX1: begin
               if (div_qc > CW'(sw_ff)) ix1_ff <= IW'(sw_ff) - IW'(1);
               else ix1_ff <= IW'(div_qc - CW'(1));
            end
            aar_pkg::DIV_IY0: sy_ff <= IW'(div_qc);
            aar_pkg::DIV_IY1: begin
               if (div_qc > CW'(sh_ff)) iy1_ff <= IW'(sh_ff) - IW'(1);
               else iy1_ff <= IW'(div_qc - CW'(1));
            end
            aar_pkg::DIV_ALPHA: res_a_ff <= aar_pkg::sat8(div_quo);
            aar_pkg::DIV_RED:   res_r_ff <= aar_pkg::sat8(div_quo);
            aar_pkg::DIV_GREEN: res_g_ff <= aar_pkg::sat8(div_quo);
            default:            res_b_ff <= aar_pkg::sat8(div_quo);
         endcase
      end
      if (cmd.row_calc) begin
         row_ok_ff <= row_hi > row_lo;
         wy_ff     <= SW'(row_hi - row_lo);
         sx_ff     <= ix0_ff;
      end
      if (cmd.sy_inc) sy_ff <= sy_ff + IW'(1);
      if (cmd.col_calc) begin
         col_ok_ff <= col_hi > col_lo;
         colw_ff   <= SW'(col_hi - col_lo);
      end
      if (cmd.sx_inc) sx_ff <= sx_ff + IW'(1);
      if (cmd.wmul) w_ff <= aar_pkg::WGT_W'(colw_ff) * aar_pkg::WGT_W'(wy_ff);
      if (cmd.amul) wa_ff <= aar_pkg::WA_W'(w_ff) * aar_pkg::WA_W'(pix_ff[31:24]);
      // premultiplied accumulation
      if (cmd.acc) begin
         acc_r_ff <= acc_r_ff + aar_pkg::ACC_C_W'(wa_ff) * aar_pkg::ACC_C_W'(pix_ff[7:0]);
         acc_g_ff <= acc_g_ff + aar_pkg::ACC_C_W'(wa_ff) * aar_pkg::ACC_C_W'(pix_ff[15:8]);
         acc_b_ff <= acc_b_ff + aar_pkg::ACC_C_W'(wa_ff) * aar_pkg::ACC_C_W'(pix_ff[23:16]);
         acc_a_ff <= acc_a_ff + aar_pkg::ACC_A_W'(wa_ff);
         wsum_ff  <= wsum_ff + aar_pkg::WSUM_W'(w_ff);
      end
   end

   // output register
   logic                          rsp_valid_ff;
   logic [aar_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {2'b00, res_a_ff, res_b_ff, res_g_ff, res_r_ff, dy_ff, dx_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // status to controller
   always_comb begin
      status.in_range = ({1'b0, dst_col} < dw_ff) && ({1'b0, dst_row} < dh_ff);
      status.row_ok   = row_ok_ff;
      status.col_ok   = col_ok_ff;
      status.sx_last  = sx_ff == ix1_ff;
      status.sy_last  = sy_ff == iy1_ff;
      status.wsum_nz  = wsum_ff != '0;
      status.acca_nz  = acc_a_ff != '0;
      status.div_done = div_done;
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

endmodule

### src/aar_ctrl.sv
// aar_ctrl: controller that sequences writes, the footprint walk and the divisions
// uses aar_pkg; steers aar_dp through command and status structs
`timescale 1ns / 1ps

module aar_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tuser,
   output logic                req_tready,
   input  aar_pkg::status_type status,
   output aar_pkg::cmd_type    cmd
);

   aar_pkg::state_type   state_ff, state_in;
   aar_pkg::div_sel_type sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aar_pkg::ST_IDLE;
         sel_ff   <= aar_pkg::DIV_IX0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.div_sel = sel_ff;
      unique case (state_ff)
         aar_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == aar_pkg::MODE_WRITE) begin
                  cmd.accept_write = 1'b1;
               end else begin
                  cmd.accept_req = 1'b1;
                  state_in = status.in_range ? aar_pkg::ST_EDGE_X : aar_pkg::ST_OUT;
               end
            end
         end
         aar_pkg::ST_EDGE_X: begin
            cmd.edge_x = 1'b1;
            state_in   = aar_pkg::ST_EDGE_Y;
         end
         aar_pkg::ST_EDGE_Y: begin
            cmd.edge_y = 1'b1;
            sel_in     = aar_pkg::DIV_IX0;
            state_in   = aar_pkg::ST_DIV_GO;
         end
         aar_pkg::ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = aar_pkg::ST_DIV_WAIT;
         end
         aar_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = aar_pkg::ST_DIV_GO;
               case (sel_ff)
                  aar_pkg::DIV_IX0: sel_in = aar_pkg::DIV_IX1;
                  aar_pkg::DIV_IX1: sel_in = aar_pkg::DIV_IY0;
                  aar_pkg::DIV_IY0: sel_in = aar_pkg::DIV_IY1;
                  aar_pkg::DIV_IY1: state_in = aar_pkg::ST_ROW;
                  aar_pkg::DIV_ALPHA: begin
                     if (status.acca_nz) sel_in = aar_pkg::DIV_RED;
                     else state_in = aar_pkg::ST_OUT;
                  end
                  aar_pkg::DIV_RED:   sel_in = aar_pkg::DIV_GREEN;
                  aar_pkg::DIV_GREEN: sel_in = aar_pkg::DIV_BLUE;
                  default:            state_in = aar_pkg::ST_OUT;
               endcase
            end
         end
         aar_pkg::ST_ROW: begin
            cmd.row_calc = 1'b1;
            state_in     = aar_pkg::ST_ROW_CHK;
         end
         aar_pkg::ST_ROW_CHK: begin
            state_in = status.row_ok ? aar_pkg::ST_COL : aar_pkg::ST_ROW_NEXT;
         end
         aar_pkg::ST_ROW_NEXT: begin
            if (status.sy_last) begin
               state_in = aar_pkg::ST_FINISH;
            end else begin
               cmd.sy_inc = 1'b1;
               state_in   = aar_pkg::ST_ROW;
            end
         end
         aar_pkg::ST_COL: begin
            cmd.col_calc = 1'b1;
            state_in     = aar_pkg::ST_COL_CHK;
         end
         aar_pkg::ST_COL_CHK: begin
            if (status.col_ok) begin
               cmd.wmul = 1'b1;
               state_in = aar_pkg::ST_AMUL;
            end else begin
               state_in = aar_pkg::ST_COL_NEXT;
            end
         end
         aar_pkg::ST_AMUL: begin
            cmd.amul = 1'b1;
            state_in = aar_pkg::ST_ACC;
         end
         aar_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = aar_pkg::ST_COL_NEXT;
         end
         aar_pkg::ST_COL_NEXT: begin
            if (status.sx_last) begin
               state_in = aar_pkg::ST_ROW_NEXT;
            end else begin
               cmd.sx_inc = 1'b1;
               state_in   = aar_pkg::ST_COL;
            end
         end
         aar_pkg::ST_FINISH: begin
            if (status.wsum_nz) begin
               sel_in   = aar_pkg::DIV_ALPHA;
               state_in = aar_pkg::ST_DIV_GO;
            end else begin
               state_in = aar_pkg::ST_OUT;
            end
         end
         aar_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = aar_pkg::ST_IDLE;
            end
         end
         default: state_in = aar_pkg::ST_IDLE;
      endcase
   end

endmodule

### src/area_average_rgba_downscaler_core.sv
// area_average_rgba_downscaler_core: top level of the area average RGBA downscaler
// instantiates aar_ctrl and aar_dp; uses aar_pkg
`timescale 1ns / 1ps

// Area-weighted RGBA resampler. A write item (tuser 0) stores one source pixel in the
// on-chip frame store. A request item (tuser 1) walks the source pixels under the destination
// footprint, weights each by its exact overlap, accumulates alpha-premultiplied color and
// returns one result item. A request sets up the footprint, visits each source row and each
// overlapping source pixel in it and ends with the divisions for the result: the shared divider
// produces one quotient bit per cycle and is used for the four footprint bounds and the alpha
// and color results. Requests outside the destination size return zeros. The frame store
// holds garbage after reset and needs no clearing pass; read only pixels that were written.
// The user must write the registers only while no request is in flight; the block itself
// does not enforce this.

module area_average_rgba_downscaler_core #(
   parameter int MAX_WIDTH  = aar_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = aar_pkg::MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_we,
   input  logic [aar_pkg::CSR_A_W-1:0]    csr_addr,
   input  logic [aar_pkg::REG_W-1:0]      csr_wdata,
   // input items
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // src_col, src_row, in_red, in_green, in_blue, in_alpha, dst_col, dst_row, zero pad
   input  logic [aar_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                           req_tuser,
   // result items
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_col, out_row, out_red, out_green, out_blue, out_alpha, zero pad
   output logic [aar_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   aar_pkg::cmd_type    cmd;
   aar_pkg::status_type status;

   aar_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   aar_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
